/* rtl/core/lnws_pkg.sv */
// Shared types, codes and constants of the LCD nibble write sequencer.
`default_nettype none
package lnws_pkg;

    localparam int VALUE_W    = 16;
    localparam int WAIT_W     = 16;
    localparam int MAX_DIGITS = 5;
    localparam int BCD_W      = 4 * MAX_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int INIT_COUNT = 7;
    localparam int INIT_IDX_W = $clog2(INIT_COUNT);

    localparam logic [WAIT_W-1:0] EDGE_WAIT_RESET  = 16'd1000;
    localparam logic [WAIT_W-1:0] POWER_WAIT_RESET = 16'd40000;
    localparam logic [WAIT_W-1:0] INIT_WAIT_A      = 16'd39;
    localparam logic [WAIT_W-1:0] INIT_WAIT_B      = 16'd37;

    localparam logic [7:0] CMD_LINE1  = 8'h80;
    localparam logic [7:0] CMD_LINE2  = 8'hC0;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    // Configuration register indexes.
    localparam logic CFG_EDGE_WAIT  = 1'b0;
    localparam logic CFG_POWER_WAIT = 1'b1;

    typedef enum logic [2:0] {
        FUNC_INIT = 3'd0,
        FUNC_CMD  = 3'd1,
        FUNC_DATA = 3'd2,
        FUNC_NUM  = 3'd3,
        FUNC_LINE = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        BSEL_INIT,
        BSEL_VALUE,
        BSEL_LINE,
        BSEL_DIGIT
    } t_byte_sel;

    typedef enum logic [1:0] {
        EXTRA_NONE,
        EXTRA_A,
        EXTRA_B
    } t_extra;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POWER,
        S_CONV,
        S_SKIP,
        S_PHASE
    } t_state;

    typedef struct packed {
        logic                  capture;
        logic                  bcd_clear;
        logic                  bcd_shift;
        logic                  digit_pop;
        logic                  byte_load;
        t_byte_sel             byte_sel;
        logic [INIT_IDX_W-1:0] init_idx;
        logic                  emit;
        logic                  emit_power;
        logic [1:0]            phase;
        t_extra                extra;
        logic                  last;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       out_free;
        logic       line1;
        logic       line2;
        logic       top_zero;
    } t_dp_status;

    function automatic logic [7:0] init_cmd(input logic [INIT_IDX_W-1:0] idx);
        logic [7:0] cmd;
        case (idx)
            3'd0:    cmd = 8'h03;
            3'd1:    cmd = 8'h02;
            3'd2:    cmd = 8'h28;
            3'd3:    cmd = 8'h08;
            3'd4:    cmd = 8'h01;
            3'd5:    cmd = 8'h06;
            3'd6:    cmd = 8'h0F;
            default: cmd = 8'h00;
        endcase
        return cmd;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/lnws_ctrl.sv */
// Controller state machine of the LCD nibble write sequencer.
`default_nettype none
module lnws_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire lnws_pkg::t_dp_status i_status,
    output lnws_pkg::t_dp_cmd         o_cmd
);

    lnws_pkg::t_state                      r_state, n_state;
    logic [lnws_pkg::CNT_W-1:0]            r_bit_cnt, n_bit_cnt;
    logic [lnws_pkg::DIG_CNT_W-1:0]        r_digits, n_digits;
    logic [lnws_pkg::INIT_IDX_W-1:0]       r_init_idx, n_init_idx;
    logic [1:0]                            r_phase, n_phase;
    logic                                  more;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lnws_pkg::S_IDLE;
            r_bit_cnt  <= '0;
            r_digits   <= '0;
            r_init_idx <= '0;
            r_phase    <= '0;
        end else begin
            r_state    <= n_state;
            r_bit_cnt  <= n_bit_cnt;
            r_digits   <= n_digits;
            r_init_idx <= n_init_idx;
            r_phase    <= n_phase;
        end
    end

    // Another byte follows the current one within this item.
    always_comb begin
        case (i_status.func)
            lnws_pkg::FUNC_INIT: more = (r_init_idx != lnws_pkg::INIT_IDX_W'(lnws_pkg::INIT_COUNT - 1));
            lnws_pkg::FUNC_NUM:  more = (r_digits != '0);
            default:             more = 1'b0;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_bit_cnt  = r_bit_cnt;
        n_digits   = r_digits;
        n_init_idx = r_init_idx;
        n_phase    = r_phase;
        o_in_stall = (r_state != lnws_pkg::S_IDLE);
        o_cmd            = '0;
        o_cmd.byte_sel   = lnws_pkg::BSEL_INIT;
        o_cmd.extra      = lnws_pkg::EXTRA_NONE;
        o_cmd.phase      = r_phase;
        o_cmd.init_idx   = r_init_idx;

        case (r_state)
            lnws_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = lnws_pkg::S_DECODE;
                end
            end
            lnws_pkg::S_DECODE: begin
                n_phase = '0;
                case (i_status.func)
                    lnws_pkg::FUNC_INIT: begin
                        n_state = lnws_pkg::S_POWER;
                    end
                    lnws_pkg::FUNC_CMD, lnws_pkg::FUNC_DATA: begin
                        o_cmd.byte_load = 1'b1;
                        o_cmd.byte_sel  = lnws_pkg::BSEL_VALUE;
                        n_state         = lnws_pkg::S_PHASE;
                    end
                    lnws_pkg::FUNC_NUM: begin
                        o_cmd.bcd_clear = 1'b1;
                        n_bit_cnt       = '0;
                        n_state         = lnws_pkg::S_CONV;
                    end
                    lnws_pkg::FUNC_LINE: begin
                        if (i_status.line1 || i_status.line2) begin
                            o_cmd.byte_load = 1'b1;
                            o_cmd.byte_sel  = lnws_pkg::BSEL_LINE;
                            n_state         = lnws_pkg::S_PHASE;
                        end else begin
                            n_state = lnws_pkg::S_IDLE;
                        end
                    end
                    default: n_state = lnws_pkg::S_IDLE;
                endcase
            end
            lnws_pkg::S_POWER: begin
                if (i_status.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_power = 1'b1;
                    o_cmd.byte_load  = 1'b1;
                    o_cmd.byte_sel   = lnws_pkg::BSEL_INIT;
                    o_cmd.init_idx   = '0;
                    n_init_idx       = '0;
                    n_state          = lnws_pkg::S_PHASE;
                end
            end
            lnws_pkg::S_CONV: begin
                o_cmd.bcd_shift = 1'b1;
                n_bit_cnt       = r_bit_cnt + 1'b1;
                if (r_bit_cnt == lnws_pkg::CNT_W'(lnws_pkg::VALUE_W - 1)) begin
                    n_digits = lnws_pkg::DIG_CNT_W'(lnws_pkg::MAX_DIGITS);
                    n_state  = lnws_pkg::S_SKIP;
                end
            end
            lnws_pkg::S_SKIP: begin
                // Drop leading zero digits but always keep the last one.
                o_cmd.digit_pop = 1'b1;
                n_digits        = r_digits - 1'b1;
                if (!(i_status.top_zero && r_digits > 1)) begin
                    o_cmd.byte_load = 1'b1;
                    o_cmd.byte_sel  = lnws_pkg::BSEL_DIGIT;
                    n_state         = lnws_pkg::S_PHASE;
                end
            end
            lnws_pkg::S_PHASE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_phase    = r_phase + 1'b1;
                    if (r_phase == 2'd3) begin
                        if (i_status.func == lnws_pkg::FUNC_INIT) begin
                            if (r_init_idx == '0) begin
                                o_cmd.extra = lnws_pkg::EXTRA_A;
                            end else if (r_init_idx == lnws_pkg::INIT_IDX_W'(2)) begin
                                o_cmd.extra = lnws_pkg::EXTRA_B;
                            end
                        end
                        if (more) begin
                            o_cmd.byte_load = 1'b1;
                            if (i_status.func == lnws_pkg::FUNC_INIT) begin
                                o_cmd.byte_sel = lnws_pkg::BSEL_INIT;
                                o_cmd.init_idx = r_init_idx + 1'b1;
                                n_init_idx     = r_init_idx + 1'b1;
                            end else begin
                                o_cmd.byte_sel  = lnws_pkg::BSEL_DIGIT;
                                o_cmd.digit_pop = 1'b1;
                                n_digits        = r_digits - 1'b1;
                            end
                        end else begin
                            o_cmd.last = 1'b1;
                            n_state    = lnws_pkg::S_IDLE;
                        end
                    end
                end
            end
            default: n_state = lnws_pkg::S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/lnws_dp.sv */
// Datapath of the LCD nibble write sequencer: registers, decimal conversion, result register.
`default_nettype none
module lnws_dp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    input  wire logic                                 i_cfg_index,
    input  wire logic [lnws_pkg::WAIT_W-1:0]          i_cfg_data,
    input  wire logic [2:0]                           i_func,
    input  wire logic [lnws_pkg::VALUE_W-1:0]         i_value,
    input  wire lnws_pkg::t_dp_cmd                    i_cmd,
    output lnws_pkg::t_dp_status                      o_status,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic                                      o_reg_select,
    output logic [3:0]                                o_nibble,
    output logic                                      o_enable,
    output logic [lnws_pkg::WAIT_W-1:0]               o_wait_us,
    output logic                                      o_last
);

    logic [lnws_pkg::WAIT_W-1:0]  r_edge_wait, r_power_wait;
    logic [2:0]                   r_func;
    logic [lnws_pkg::VALUE_W-1:0] r_value;
    logic [lnws_pkg::BCD_W-1:0]   r_bcd, bcd_adj;
    logic [lnws_pkg::VALUE_W-1:0] r_bin;
    logic [7:0]                   r_byte, n_byte;
    logic                         r_rs, n_rs;
    logic                         r_out_valid;
    logic                         r_o_rs, r_o_en, r_o_last;
    logic [3:0]                   r_o_nib;
    logic [lnws_pkg::WAIT_W-1:0]  r_o_wait;
    logic [lnws_pkg::WAIT_W-1:0]  extra;
    logic [lnws_pkg::WAIT_W:0]    wait_sum;
    logic [lnws_pkg::WAIT_W-1:0]  phase_wait;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_wait  <= lnws_pkg::EDGE_WAIT_RESET;
            r_power_wait <= lnws_pkg::POWER_WAIT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == lnws_pkg::CFG_EDGE_WAIT) begin
                r_edge_wait <= i_cfg_data;
            end else begin
                r_power_wait <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func <= lnws_pkg::FUNC_INIT;
        end else if (i_cmd.capture) begin
            r_func <= i_func;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_value <= i_value;
        end
    end

    // Shift-and-add-3 step: each BCD digit of five or more is corrected before the shift.
    always_comb begin
        for (int d = 0; d < lnws_pkg::MAX_DIGITS; d++) begin
            bcd_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                          : r_bcd[4*d +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bcd_clear) begin
            r_bcd <= '0;
            r_bin <= r_value;
        end else if (i_cmd.bcd_shift) begin
            r_bcd <= {bcd_adj[lnws_pkg::BCD_W-2:0], r_bin[lnws_pkg::VALUE_W-1]};
            r_bin <= {r_bin[lnws_pkg::VALUE_W-2:0], 1'b0};
        end else if (i_cmd.digit_pop) begin
            r_bcd <= {r_bcd[lnws_pkg::BCD_W-5:0], 4'b0};
        end
    end

    always_comb begin
        case (i_cmd.byte_sel)
            lnws_pkg::BSEL_INIT: begin
                n_byte = lnws_pkg::init_cmd(i_cmd.init_idx);
                n_rs   = 1'b0;
            end
            lnws_pkg::BSEL_VALUE: begin
                n_byte = r_value[7:0];
                n_rs   = (r_func == lnws_pkg::FUNC_DATA);
            end
            lnws_pkg::BSEL_LINE: begin
                n_byte = (r_value == lnws_pkg::VALUE_W'(1)) ? lnws_pkg::CMD_LINE1
                                                           : lnws_pkg::CMD_LINE2;
                n_rs   = 1'b0;
            end
            lnws_pkg::BSEL_DIGIT: begin
                n_byte = lnws_pkg::ASCII_ZERO | {4'b0, r_bcd[lnws_pkg::BCD_W-1 -: 4]};
                n_rs   = 1'b1;
            end
            default: begin
                n_byte = '0;
                n_rs   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_load) begin
            r_byte <= n_byte;
            r_rs   <= n_rs;
        end
    end

    always_comb begin
        case (i_cmd.extra)
            lnws_pkg::EXTRA_A: extra = lnws_pkg::INIT_WAIT_A;
            lnws_pkg::EXTRA_B: extra = lnws_pkg::INIT_WAIT_B;
            default:           extra = '0;
        endcase
        wait_sum   = {1'b0, r_edge_wait} + {1'b0, extra};
        phase_wait = wait_sum[lnws_pkg::WAIT_W] ? '1 : wait_sum[lnws_pkg::WAIT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (i_cmd.emit_power) begin
                r_o_rs   <= 1'b0;
                r_o_nib  <= '0;
                r_o_en   <= 1'b0;
                r_o_wait <= r_power_wait;
            end else begin
                r_o_rs   <= r_rs;
                r_o_nib  <= i_cmd.phase[1] ? r_byte[3:0] : r_byte[7:4];
                r_o_en   <= ~i_cmd.phase[0];
                r_o_wait <= phase_wait;
            end
            r_o_last <= i_cmd.last;
        end
    end

    assign o_status.func     = r_func;
    assign o_status.out_free = ~r_out_valid | ~i_out_stall;
    assign o_status.line1    = (r_value == lnws_pkg::VALUE_W'(1));
    assign o_status.line2    = (r_value == lnws_pkg::VALUE_W'(2));
    assign o_status.top_zero = (r_bcd[lnws_pkg::BCD_W-1 -: 4] == 4'd0);

    assign o_out_valid  = r_out_valid;
    assign o_reg_select = r_o_rs;
    assign o_nibble     = r_o_nib;
    assign o_enable     = r_o_en;
    assign o_wait_us    = r_o_wait;
    assign o_last       = r_o_last;

endmodule
`default_nettype wire

/* rtl/core/lcd_nibble_write_sequencer.sv */
// Top level of the LCD nibble write sequencer: controller and datapath.
//
// Each accepted item turns into a stream of bus phases, one phase per clock while the output
// side does not stall. A command, character or cursor item gives 4 phases; init gives 29
// phases; a number first runs a shift-and-add-3 conversion to decimal, then drops up to
// four leading zero digits one per cycle and sends 4 phases per digit. The phase emission,
// one phase per cycle from the single result register, sets the pace. One item is worked at
// a time; the input stalls until the last phase of the item has been taken into the result
// register. A cursor item for a line other than 1 or 2 and an unknown function give no phase.
`default_nettype none
module lcd_nibble_write_sequencer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic                          i_cfg_index,
    input  wire logic [lnws_pkg::WAIT_W-1:0]   i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [2:0]                    i_func,
    input  wire logic [lnws_pkg::VALUE_W-1:0]  i_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_reg_select,
    output logic [3:0]                         o_nibble,
    output logic                               o_enable,
    output logic [lnws_pkg::WAIT_W-1:0]        o_wait_us,
    output logic                               o_last
);

    lnws_pkg::t_dp_cmd    dp_cmd;
    lnws_pkg::t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    lnws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    lnws_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_func       (i_func),
        .i_value      (i_value),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_reg_select (o_reg_select),
        .o_nibble     (o_nibble),
        .o_enable     (o_enable),
        .o_wait_us    (o_wait_us),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire
